### rtl/rmst_pkg.sv
// Shared types and constants for the range maximum segment tree.
package rmst_pkg;

   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned POS_W      = 10;
   localparam int unsigned COUNT_W    = 11;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] ELEMENTS_RESET = 11'd1024;
   localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // register index as decoded from paddr[2]
   localparam logic REG_ELEMENTS_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_WRITE,
      ST_Q_LEVEL,
      ST_Q_A_WAIT,
      ST_Q_B_WAIT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic                      range_empty;
      logic                      was_query;
      logic                      update_ignored;
   } result_type;

endpackage

### rtl/rmst_channels.sv
// Request and response channel interfaces.
interface rmst_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic [rmst_pkg::POS_W-1:0]         position;
   logic signed [rmst_pkg::VALUE_W-1:0] new_value;
   logic [rmst_pkg::POS_W-1:0]         range_low;
   logic [rmst_pkg::POS_W-1:0]         range_high;

   modport source (output valid, opcode, position, new_value, range_low, range_high,
                   input ready);
   modport sink   (input valid, opcode, position, new_value, range_low, range_high,
                   output ready);
endinterface

interface rmst_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rmst_pkg::VALUE_W-1:0] max_value;
   logic                               range_empty;
   logic                               was_query;
   logic                               update_ignored;

   modport source (output valid, max_value, range_empty, was_query, update_ignored,
                   input ready);
   modport sink   (input valid, max_value, range_empty, was_query, update_ignored,
                   output ready);
endinterface

### rtl/range_max_segment_tree_top.sv
// Range maximum segment tree: top level.
//
// Requests arrive on req_chan (valid/ready). opcode 0 writes new_value to
// element position and refreshes every ancestor; opcode 1 returns the maximum
// over range_low..range_high, clipped to elements_in_use. Each request yields
// exactly one response on rsp_chan, in order.
// Nodes live in one memory of 2*MAX_ELEMENTS entries with a registered read.
// An update writes the leaf as it is accepted, then for each tree level reads
// the sibling (ST_UPD_READ) and writes the parent (ST_UPD_WRITE) up to the
// root, and then loads the response in ST_DONE. A query walks up the levels
// in ST_Q_LEVEL, folding in each boundary node through ST_Q_A_WAIT or
// ST_Q_B_WAIT; an empty or ignored request goes straight to ST_DONE. One
// request in work.
// After reset the block sweeps the memory, writing the most negative value to
// one node per cycle; req_chan.ready stays low until the sweep ends, while CSR
// writes are taken. The response sits in an output register; if rsp_chan
// stalls, the next request may be accepted but its result waits until the
// held response is taken.
// CSR: elements_in_use at byte address 0, write only while idle.
module range_max_segment_tree_top #(
   parameter int unsigned MAX_ELEMENTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   rmst_req_if.sink                        req_chan,
   rmst_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rmst_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rmst_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rmst_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int unsigned DEPTH  = 2 * MAX_ELEMENTS;
   localparam int unsigned NODE_W = $clog2(DEPTH);

   logic [rmst_pkg::COUNT_W-1:0]        elements_in_use;
   logic                                mem_we;
   logic [NODE_W-1:0]                   mem_waddr;
   logic signed [rmst_pkg::VALUE_W-1:0] mem_wdata;
   logic [NODE_W-1:0]                   mem_raddr;
   logic signed [rmst_pkg::VALUE_W-1:0] mem_rdata;

   rmst_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .elements_in_use (elements_in_use)
   );

   rmst_node_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (NODE_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rmst_seq #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .NODE_W       (NODE_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .elements_in_use (elements_in_use),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

endmodule

### rtl/rmst_node_ram.sv
// Tree node storage: one write port, one registered read port.
module rmst_node_ram #(
   parameter int unsigned DEPTH  = 2048,
   parameter int unsigned ADDR_W = 11
) (
   input  logic                               clock,
   input  logic                               we,
   input  logic [ADDR_W-1:0]                  waddr,
   input  logic signed [rmst_pkg::VALUE_W-1:0] wdata,
   input  logic [ADDR_W-1:0]                  raddr,
   output logic signed [rmst_pkg::VALUE_W-1:0] rdata
);

   logic signed [rmst_pkg::VALUE_W-1:0] nodes_ff [DEPTH];
   logic signed [rmst_pkg::VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         nodes_ff[waddr] <= wdata;
      end
      rdata_ff <= nodes_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rmst_csr.sv
// APB-style register block holding elements_in_use.
module rmst_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rmst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rmst_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rmst_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [rmst_pkg::COUNT_W-1:0]      elements_in_use
);

   logic [rmst_pkg::COUNT_W-1:0] eiu_ff;
   logic [rmst_pkg::COUNT_W-1:0] eiu_in;
   logic                         hit_eiu;
   logic                         wr_fire;

   assign hit_eiu = (csr_paddr[2] == rmst_pkg::REG_ELEMENTS_IN_USE);
   assign wr_fire = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      eiu_in = eiu_ff;
      if (wr_fire && hit_eiu) begin
         eiu_in = csr_pwdata[rmst_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff <= rmst_pkg::ELEMENTS_RESET;
      end else begin
         eiu_ff <= eiu_in;
      end
   end

   assign csr_prdata      = hit_eiu ? rmst_pkg::CSR_DATA_W'(eiu_ff) : '0;
   assign csr_pready      = 1'b1;
   assign elements_in_use = eiu_ff;

endmodule

### rtl/rmst_seq.sv
// Sequencer: clearing pass, leaf-to-root update walk and bottom-up range query.
module rmst_seq #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned NODE_W       = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [rmst_pkg::COUNT_W-1:0]       elements_in_use,
   rmst_req_if.sink                           req_chan,
   rmst_rsp_if.source                         rsp_chan,
   output logic                               mem_we,
   output logic [NODE_W-1:0]                  mem_waddr,
   output logic signed [rmst_pkg::VALUE_W-1:0] mem_wdata,
   output logic [NODE_W-1:0]                  mem_raddr,
   input  logic signed [rmst_pkg::VALUE_W-1:0] mem_rdata
);

   localparam int unsigned IDX_W   = $clog2(2 * MAX_ELEMENTS + 1);
   localparam int unsigned NEED_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned CNT_W   = (NEED_W > rmst_pkg::COUNT_W) ? NEED_W : rmst_pkg::COUNT_W;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * MAX_ELEMENTS - 1);

   rmst_pkg::seq_state_type state_ff, state_in;

   logic [NODE_W-1:0]                  clr_ff, clr_in;
   logic [IDX_W-1:0]                   a_ff, a_in;   // also the walk pointer of an update
   logic [IDX_W-1:0]                   b_ff, b_in;
   logic signed [rmst_pkg::VALUE_W-1:0] cur_ff, cur_in;
   logic                               query_ff, query_in;
   logic                               empty_ff, empty_in;
   logic                               ignored_ff, ignored_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rmst_pkg::result_type               rsp_data_ff, rsp_data_in;

   logic                               req_fire;
   logic                               out_free;
   logic                               out_load;
   logic [CNT_W-1:0]                   eiu_ext;
   logic [CNT_W-1:0]                   n_active;
   logic [CNT_W-1:0]                   n_last;
   logic [CNT_W-1:0]                   hi_clip;
   logic                               upd_ignored;
   logic                               q_empty;
   logic                               is_query;
   logic [IDX_W-1:0]                   leaf_idx;
   logic [IDX_W-1:0]                   q_a_start;
   logic [IDX_W-1:0]                   q_b_start;
   logic [IDX_W-1:0]                   parent;
   logic signed [rmst_pkg::VALUE_W-1:0] rd_max;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_query = (req_chan.opcode == rmst_pkg::OP_QUERY);

   // active element count, clipped to the tree size
   assign eiu_ext  = CNT_W'(elements_in_use);
   assign n_active = (eiu_ext > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : eiu_ext;
   assign n_last   = n_active - CNT_W'(1);

   assign upd_ignored = CNT_W'(req_chan.position) >= n_active;
   assign hi_clip     = (CNT_W'(req_chan.range_high) > n_last) ? n_last
                                                               : CNT_W'(req_chan.range_high);
   assign q_empty     = (n_active == '0) || (CNT_W'(req_chan.range_low) > hi_clip);

   assign leaf_idx  = IDX_W'(MAX_ELEMENTS) + IDX_W'(req_chan.position);
   assign q_a_start = IDX_W'(MAX_ELEMENTS) + IDX_W'(req_chan.range_low);
   assign q_b_start = IDX_W'(MAX_ELEMENTS) + IDX_W'(hi_clip) + IDX_W'(1);

   assign parent = a_ff >> 1;
   assign rd_max = (mem_rdata > cur_ff) ? mem_rdata : cur_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_NODE) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         rmst_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (is_query) begin
                  state_in = q_empty ? rmst_pkg::ST_DONE : rmst_pkg::ST_Q_LEVEL;
               end else begin
                  state_in = upd_ignored ? rmst_pkg::ST_DONE : rmst_pkg::ST_UPD_READ;
               end
            end
         end
         rmst_pkg::ST_UPD_READ: begin
            state_in = rmst_pkg::ST_UPD_WRITE;
         end
         rmst_pkg::ST_UPD_WRITE: begin
            state_in = (parent > IDX_W'(1)) ? rmst_pkg::ST_UPD_READ : rmst_pkg::ST_DONE;
         end
         rmst_pkg::ST_Q_LEVEL: begin
            if (a_ff >= b_ff) begin
               state_in = rmst_pkg::ST_DONE;
            end else if (a_ff[0]) begin
               state_in = rmst_pkg::ST_Q_A_WAIT;
            end else if (b_ff[0]) begin
               state_in = rmst_pkg::ST_Q_B_WAIT;
            end
         end
         rmst_pkg::ST_Q_A_WAIT: begin
            state_in = b_ff[0] ? rmst_pkg::ST_Q_B_WAIT : rmst_pkg::ST_Q_LEVEL;
         end
         rmst_pkg::ST_Q_B_WAIT: begin
            state_in = rmst_pkg::ST_Q_LEVEL;
         end
         rmst_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmst_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in     = clr_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      cur_in     = cur_ff;
      query_in   = query_ff;
      empty_in   = empty_ff;
      ignored_in = ignored_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = rmst_pkg::INT_MIN;
      mem_raddr  = '0;
      out_load   = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + NODE_W'(1);
         end
         rmst_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               query_in   = is_query;
               empty_in   = is_query && q_empty;
               ignored_in = !is_query && upd_ignored;
               if (is_query) begin
                  cur_in = rmst_pkg::INT_MIN;
                  a_in   = q_a_start;
                  b_in   = q_b_start;
               end else begin
                  cur_in = req_chan.new_value;
                  a_in   = leaf_idx;
                  if (!upd_ignored) begin
                     mem_we    = 1'b1;
                     mem_waddr = leaf_idx[NODE_W-1:0];
                     mem_wdata = req_chan.new_value;
                  end
               end
            end
         end
         rmst_pkg::ST_UPD_READ: begin
            // sibling of the node just written
            mem_raddr = {a_ff[NODE_W-1:1], ~a_ff[0]};
         end
         rmst_pkg::ST_UPD_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = parent[NODE_W-1:0];
            mem_wdata = rd_max;
            cur_in    = rd_max;
            a_in      = parent;
         end
         rmst_pkg::ST_Q_LEVEL: begin
            if (a_ff < b_ff) begin
               if (a_ff[0]) begin
                  mem_raddr = a_ff[NODE_W-1:0];
                  a_in      = a_ff + IDX_W'(1);
               end else if (b_ff[0]) begin
                  mem_raddr = NODE_W'(b_ff - IDX_W'(1));
                  b_in      = b_ff - IDX_W'(1);
               end else begin
                  a_in = a_ff >> 1;
                  b_in = b_ff >> 1;
               end
            end
         end
         rmst_pkg::ST_Q_A_WAIT: begin
            cur_in = rd_max;
            if (b_ff[0]) begin
               mem_raddr = NODE_W'(b_ff - IDX_W'(1));
               b_in      = b_ff - IDX_W'(1);
            end else begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
            end
         end
         rmst_pkg::ST_Q_B_WAIT: begin
            cur_in = rd_max;
            a_in   = a_ff >> 1;
            b_in   = b_ff >> 1;
         end
         rmst_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in                = rsp_data_ff;
      rsp_valid_in               = rsp_valid_ff && !rsp_chan.ready;
      if (out_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.max_value      = query_ff ? cur_ff : '0;
         rsp_data_in.range_empty    = empty_ff;
         rsp_data_in.was_query      = query_ff;
         rsp_data_in.update_ignored = ignored_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      query_ff    <= query_in;
      empty_ff    <= empty_in;
      ignored_ff  <= ignored_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.max_value      = rsp_data_ff.max_value;
   assign rsp_chan.range_empty    = rsp_data_ff.range_empty;
   assign rsp_chan.was_query      = rsp_data_ff.was_query;
   assign rsp_chan.update_ignored = rsp_data_ff.update_ignored;

endmodule

### rtl/rmst_checker.sv
// Port-level checks for the segment tree top, bound to the top level.
module rmst_port_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [rmst_pkg::VALUE_W-1:0] rsp_max_value,
   input logic                                rsp_range_empty,
   input logic                                rsp_was_query,
   input logic                                rsp_update_ignored
);

   // a response stalled by the receiver stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // and its payload holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_max_value) && $stable(rsp_range_empty)
         && $stable(rsp_was_query) && $stable(rsp_update_ignored))
      else $error("stalled response payload changed");

   // update acknowledgements carry zero value and no empty flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_query |-> rsp_max_value == '0 && !rsp_range_empty)
      else $error("update acknowledgement carries query fields");

   // query results never flag an ignored update; empty means most negative value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_query |-> !rsp_update_ignored
         && (!rsp_range_empty || rsp_max_value == rmst_pkg::INT_MIN))
      else $error("malformed query result");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

endmodule

bind range_max_segment_tree_top rmst_port_checker u_rmst_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_max_value      (rsp_chan.max_value),
   .rsp_range_empty    (rsp_chan.range_empty),
   .rsp_was_query      (rsp_chan.was_query),
   .rsp_update_ignored (rsp_chan.update_ignored)
);

### test/rmst_checker.sv
`timescale 1ns / 100ps
// Segment tree checker: snoops requests and CSR writes, predicts and compares responses.
module rmst_checker #(
   parameter int unsigned MAX_ELEMENTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   rmst_req_if                             req_mon,
   rmst_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [rmst_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rmst_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int unsigned                     outstanding,
   output int unsigned                     fail_count
);

   // only the leaves are kept: every inner node is the max of its subtree anyway
   logic signed [rmst_pkg::VALUE_W-1:0] leaf_value [MAX_ELEMENTS];
   logic [rmst_pkg::COUNT_W-1:0]        elements_in_use;
   rmst_pkg::result_type                expected_q [$];
   rmst_pkg::result_type                wanted;
   int unsigned                         errors = 0;

   function automatic rmst_pkg::result_type apply_request(
         input logic op,
         input logic [rmst_pkg::POS_W-1:0] pos,
         input logic signed [rmst_pkg::VALUE_W-1:0] value,
         input logic [rmst_pkg::POS_W-1:0] lo,
         input logic [rmst_pkg::POS_W-1:0] hi);
      rmst_pkg::result_type res;
      int unsigned n;
      int unsigned top_idx;
      int unsigned idx;
      res = '0;
      n = (elements_in_use > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elements_in_use);
      if (op == rmst_pkg::OP_UPDATE) begin
         if (pos >= n) begin
            res.update_ignored = 1'b1;
         end else begin
            leaf_value[pos] = value;
         end
      end else begin
         res.was_query = 1'b1;
         res.max_value = rmst_pkg::INT_MIN;
         if (n == 0) begin
            res.range_empty = 1'b1;
         end else begin
            top_idx = (hi > n - 1) ? n - 1 : hi;
            res.range_empty = (lo > top_idx);
            if (!res.range_empty) begin
               for (idx = lo; idx <= top_idx; idx++) begin
                  if (leaf_value[idx] > res.max_value) res.max_value = leaf_value[idx];
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (leaf_value[i]) leaf_value[i] = rmst_pkg::INT_MIN;
         elements_in_use = rmst_pkg::ELEMENTS_RESET;
         expected_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request waiting");
               errors++;
            end else begin
               wanted = expected_q.pop_front();
               if (rsp_mon.max_value !== wanted.max_value) begin
                  $error("max_value: expected %0d, got %0d", wanted.max_value,
                         rsp_mon.max_value);
                  errors++;
               end
               if (rsp_mon.range_empty !== wanted.range_empty) begin
                  $error("range_empty: expected %0d, got %0d", wanted.range_empty,
                         rsp_mon.range_empty);
                  errors++;
               end
               if (rsp_mon.was_query !== wanted.was_query) begin
                  $error("was_query: expected %0d, got %0d", wanted.was_query,
                         rsp_mon.was_query);
                  errors++;
               end
               if (rsp_mon.update_ignored !== wanted.update_ignored) begin
                  $error("update_ignored: expected %0d, got %0d", wanted.update_ignored,
                         rsp_mon.update_ignored);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(apply_request(req_mon.opcode, req_mon.position,
                                               req_mon.new_value, req_mon.range_low,
                                               req_mon.range_high));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == rmst_pkg::REG_ELEMENTS_IN_USE) begin
            elements_in_use = csr_pwdata[rmst_pkg::COUNT_W-1:0];
         end
         outstanding <= expected_q.size();
      end
      fail_count <= errors;
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Segment tree testbench top: clock, reset, request and CSR stimulus, verdict.
module tb_top;

   localparam int unsigned MAX_ELEMENTS    = 1024;
   localparam int unsigned SETTLE_CYCLES   = 40;
   localparam int unsigned WATCHDOG_LIMIT  = 20000;
   localparam int unsigned ITEMS_PER_PHASE = 85;
   localparam int unsigned NUM_PHASES      = 10;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [rmst_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rmst_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rmst_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned req_gap_max   = 19;
   int unsigned rsp_stall_max = 19;
   int unsigned rsp_stall_left;
   int unsigned stall_draw;
   int unsigned active_count  = MAX_ELEMENTS;
   int unsigned idle_cycles   = 0;
   int unsigned phase_counts [NUM_PHASES] = '{1024, 5, 1, 64, 2047, 0, 300, 17, 2, 1024};

   rmst_req_if req_if ();
   rmst_rsp_if rsp_if ();

   range_max_segment_tree_top #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   rmst_checker #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_pready (csr_pready),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .outstanding(outstanding),
      .fail_count (fail_count)
   );

   always #4 clock = ~clock;

   // response side: random stall after each taken response
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         stall_draw = $urandom_range(0, rsp_stall_max);
         rsp_stall_left <= stall_draw;
         rsp_if.ready <= (stall_draw == 0);
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_if.ready <= (rsp_stall_left == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_elements(input int unsigned count);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= rmst_pkg::CSR_ADDR_W'({rmst_pkg::REG_ELEMENTS_IN_USE, 2'b00});
      csr_pwdata <= rmst_pkg::CSR_DATA_W'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      active_count = (count > MAX_ELEMENTS) ? MAX_ELEMENTS : count;
   endtask

   // valid stays high across back-to-back requests; within this task it drops only for a gap
   task automatic send_request(input logic op, input logic [rmst_pkg::POS_W-1:0] pos,
                               input logic signed [rmst_pkg::VALUE_W-1:0] value,
                               input logic [rmst_pkg::POS_W-1:0] lo,
                               input logic [rmst_pkg::POS_W-1:0] hi);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.opcode     <= op;
      req_if.position   <= pos;
      req_if.new_value  <= value;
      req_if.range_low  <= lo;
      req_if.range_high <= hi;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic signed [rmst_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return rmst_pkg::INT_MIN;
         1:       return ~rmst_pkg::INT_MIN;
         2:       return '1;
         3:       return rmst_pkg::VALUE_W'(int'($urandom_range(0, 200)) - 100);
         default: return rmst_pkg::VALUE_W'($urandom());
      endcase
   endfunction

   task automatic random_request();
      int unsigned                pick;
      int unsigned                span;
      logic [rmst_pkg::POS_W-1:0] pos;
      logic [rmst_pkg::POS_W-1:0] lo;
      logic [rmst_pkg::POS_W-1:0] hi;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (active_count != 0 && $urandom_range(0, 9) != 0) begin
            pos = rmst_pkg::POS_W'($urandom_range(0, active_count - 1));
         end else begin
            pos = rmst_pkg::POS_W'($urandom());
         end
         send_request(rmst_pkg::OP_UPDATE, pos, random_value(),
                      rmst_pkg::POS_W'($urandom()), rmst_pkg::POS_W'($urandom()));
      end else begin
         if (pick < 90 && active_count != 0) begin
            lo = rmst_pkg::POS_W'($urandom_range(0, active_count - 1));
            span = ($urandom_range(0, 3) == 0) ? MAX_ELEMENTS : $urandom_range(0, 15);
            hi = (lo + span > MAX_ELEMENTS - 1) ? rmst_pkg::POS_W'(MAX_ELEMENTS - 1)
                                                : rmst_pkg::POS_W'(lo + span);
         end else begin
            // anything goes: reversed, past the end, full width
            lo = rmst_pkg::POS_W'($urandom());
            hi = rmst_pkg::POS_W'($urandom());
         end
         send_request(rmst_pkg::OP_QUERY, rmst_pkg::POS_W'($urandom()),
                      rmst_pkg::VALUE_W'($urandom()), lo, hi);
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned count;
      req_if.valid      = 1'b0;
      req_if.opcode     = rmst_pkg::OP_UPDATE;
      req_if.position   = '0;
      req_if.new_value  = '0;
      req_if.range_low  = '0;
      req_if.range_high = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tree, extremes of values and positions, clipping
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd0, 10'd1023);
      send_request(rmst_pkg::OP_UPDATE, 10'd0, ~rmst_pkg::INT_MIN, '0, '0);
      send_request(rmst_pkg::OP_UPDATE, 10'd1023, rmst_pkg::INT_MIN, '0, '0);
      send_request(rmst_pkg::OP_UPDATE, 10'd512, -32'sd1, '0, '0);
      send_request(rmst_pkg::OP_UPDATE, 10'd1, 32'sd0, '0, '0);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd1023, 10'd1023);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd0, 10'd1023);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd1, 10'd1023);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd5, 10'd3);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd2, 10'd511);
      wait_drained();
      write_elements(1);
      send_request(rmst_pkg::OP_UPDATE, 10'd1, 32'sd7, '0, '0);
      send_request(rmst_pkg::OP_UPDATE, 10'd1023, 32'sd7, '0, '0);
      send_request(rmst_pkg::OP_UPDATE, 10'd0, -32'sd5, '0, '0);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd0, 10'd1023);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd1, 10'd1);
      wait_drained();
      write_elements(0);
      send_request(rmst_pkg::OP_UPDATE, 10'd0, 32'sd9, '0, '0);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd0, 10'd0);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd0, 10'd1023);
      wait_drained();
      // above the maximum: behaves as a full tree, old values still there
      write_elements(2047);
      send_request(rmst_pkg::OP_UPDATE, 10'd1023, 32'sd123, '0, '0);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd0, 10'd1023);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd1000, 10'd1023);
      send_request(rmst_pkg::OP_QUERY, '0, '0, 10'd1023, 10'd0);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         count = (phase == NUM_PHASES - 1) ? $urandom_range(1, MAX_ELEMENTS)
                                           : phase_counts[phase];
         write_elements(count);
         req_gap_max   = (phase % 3 == 0) ? 0 : 19;
         rsp_stall_max = (phase % 4 == 1) ? 0 : 19;
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 49) == 0) wait_drained();
            random_request();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### range_max_segment_tree_top.f
rtl/rmst_pkg.sv
rtl/rmst_channels.sv
rtl/rmst_node_ram.sv
rtl/rmst_csr.sv
rtl/rmst_seq.sv
rtl/range_max_segment_tree_top.sv
rtl/rmst_checker.sv
test/rmst_checker.sv
test/tb_top.sv
